[rtl/drt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types and constants of the divider and reloading timer unit.
// ----------------------------------------------------------------------------
package drt_pkg;

	localparam int BUDGET_W = 12;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_NONE  = 2'd3
	} command_t;

	localparam logic [2:0] OFS_DIVIDER = 3'd0;
	localparam logic [2:0] OFS_COUNTER = 3'd1;
	localparam logic [2:0] OFS_MODULO  = 3'd2;
	localparam logic [2:0] OFS_CONTROL = 3'd3;

	localparam logic [7:0] RATE_MASK   = 8'h03;
	localparam logic [7:0] UNMAPPED_RD = 8'h00;
	localparam int         RUN_BIT     = 2;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] elapsed_cycles;
		logic [2:0] reg_offset;
		logic [7:0] write_data;
	} in_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       timer_irq;
	} out_t;

	typedef struct packed {
		logic load;
		logic sub;
		logic step;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic cnt_done;
	} ctrl_status_t;

endpackage
`default_nettype wire

[rtl/drt_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// drt_ctrl
// Sequencer: accepts one beat, runs subtract and step passes for a tick, emits a result.
// ----------------------------------------------------------------------------
module drt_ctrl
	import drt_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [1:0]   in_command,
	output logic              out_valid,
	input  wire logic         out_ready,
	input  wire ctrl_status_t status,
	output ctrl_cmd_t         cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SUB,
		ST_STEP,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load = in_valid && (state_q == ST_IDLE);
		cmd.sub  = (state_q == ST_SUB);
		cmd.step = (state_q == ST_STEP);
		cmd.emit = (state_q == ST_DONE) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && !out_ready) || ((state_q == ST_DONE) && slot_free);
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (in_command == CMD_TICK)
							state_q <= ST_SUB;
						else
							state_q <= ST_DONE;
					end
				end
				ST_SUB: begin
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (status.div_done && status.cnt_done)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/drt_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// drt_datapath
// Timer registers, budget arithmetic and the result register.
// ----------------------------------------------------------------------------
module drt_datapath
	import drt_pkg::*;
#(
	parameter int DIVIDER_PERIOD = 256,
	parameter int RATE0_PERIOD   = 1024,
	parameter int RATE1_PERIOD   = 16,
	parameter int RATE2_PERIOD   = 64,
	parameter int RATE3_PERIOD   = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire in_t   in_data,
	input  wire ctrl_cmd_t cmd,
	output ctrl_status_t status,
	output out_t       out_data
);

	localparam logic signed [BUDGET_W-1:0] DIV_P = BUDGET_W'(DIVIDER_PERIOD);
	localparam logic signed [BUDGET_W-1:0] R0_P  = BUDGET_W'(RATE0_PERIOD);
	localparam logic signed [BUDGET_W-1:0] R1_P  = BUDGET_W'(RATE1_PERIOD);
	localparam logic signed [BUDGET_W-1:0] R2_P  = BUDGET_W'(RATE2_PERIOD);
	localparam logic signed [BUDGET_W-1:0] R3_P  = BUDGET_W'(RATE3_PERIOD);
	localparam logic signed [BUDGET_W-1:0] BUDGET_MIN = {1'b1, {(BUDGET_W-1){1'b0}}};

	logic [7:0]                  div_value_q;
	logic signed [BUDGET_W-1:0]  div_budget_q;
	logic [7:0]                  cnt_value_q;
	logic signed [BUDGET_W-1:0]  cnt_budget_q;
	logic                        cnt_running_q;
	logic [7:0]                  modulo_q;
	logic [7:0]                  control_q;

	logic [7:0]                  cycles_q;
	logic signed [BUDGET_W-1:0]  cnt_period_q;
	logic                        div_done_q;
	logic                        cnt_done_q;
	logic [7:0]                  rdata_q;
	logic                        irq_q;
	out_t                        out_q;

	logic signed [BUDGET_W-1:0]  rate_period;
	logic signed [BUDGET_W-1:0]  div_sub;
	logic signed [BUDGET_W-1:0]  cnt_sub;
	logic                        div_le0;
	logic                        cnt_le0;
	logic [7:0]                  read_mux;

	function automatic logic signed [BUDGET_W-1:0] sat_sub(
		input logic signed [BUDGET_W-1:0] b,
		input logic [7:0]                 c
	);
		logic signed [BUDGET_W:0] d;
		d = {b[BUDGET_W-1], b} - {{(BUDGET_W-7){1'b0}}, c};
		if (d[BUDGET_W] && !d[BUDGET_W-1])
			return BUDGET_MIN;
		return d[BUDGET_W-1:0];
	endfunction

	always_comb begin
		case (control_q & RATE_MASK)
			8'd0:    rate_period = R0_P;
			8'd1:    rate_period = R1_P;
			8'd2:    rate_period = R2_P;
			default: rate_period = R3_P;
		endcase
	end

	always_comb begin
		case (in_data.reg_offset)
			OFS_DIVIDER: read_mux = div_value_q;
			OFS_COUNTER: read_mux = cnt_value_q;
			OFS_MODULO:  read_mux = modulo_q;
			OFS_CONTROL: read_mux = control_q;
			default:     read_mux = UNMAPPED_RD;
		endcase
	end

	assign div_sub = sat_sub(div_budget_q, cycles_q);
	assign cnt_sub = sat_sub(cnt_budget_q, cycles_q);
	assign div_le0 = div_budget_q[BUDGET_W-1] || (div_budget_q == '0);
	assign cnt_le0 = cnt_budget_q[BUDGET_W-1] || (cnt_budget_q == '0);

	assign status.div_done = div_done_q;
	assign status.cnt_done = cnt_done_q;
	assign out_data        = out_q;

	// timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_value_q   <= '0;
			div_budget_q  <= DIV_P;
			cnt_value_q   <= '0;
			cnt_budget_q  <= R0_P;
			cnt_running_q <= 1'b0;
			modulo_q      <= '0;
			control_q     <= '0;
			div_done_q    <= 1'b1;
			cnt_done_q    <= 1'b1;
			irq_q         <= 1'b0;
		end else begin
			if (cmd.load) begin
				irq_q <= 1'b0;
				if (in_data.command == CMD_TICK) begin
					div_done_q <= 1'b0;
					cnt_done_q <= !cnt_running_q;
				end else if (in_data.command == CMD_WRITE) begin
					case (in_data.reg_offset)
						OFS_DIVIDER: div_value_q <= '0;
						OFS_COUNTER: cnt_value_q <= in_data.write_data;
						OFS_MODULO:  modulo_q    <= in_data.write_data;
						OFS_CONTROL: begin
							control_q     <= in_data.write_data;
							cnt_running_q <= in_data.write_data[RUN_BIT];
						end
						default: begin
						end
					endcase
				end
			end
			if (cmd.sub) begin
				div_budget_q <= div_sub;
				if (!cnt_done_q)
					cnt_budget_q <= cnt_sub;
			end
			if (cmd.step) begin
				if (!div_done_q) begin
					if (div_le0) begin
						div_budget_q <= div_budget_q + DIV_P;
						div_value_q  <= div_value_q + 8'd1;
						if (div_value_q == 8'hFF)
							div_done_q <= 1'b1;
					end else begin
						div_done_q <= 1'b1;
					end
				end
				if (!cnt_done_q) begin
					if (cnt_le0) begin
						cnt_budget_q <= cnt_budget_q + cnt_period_q;
						if (cnt_value_q == 8'hFF) begin
							cnt_value_q <= modulo_q;
							irq_q       <= 1'b1;
							cnt_done_q  <= 1'b1;
						end else begin
							cnt_value_q <= cnt_value_q + 8'd1;
						end
					end else begin
						cnt_done_q <= 1'b1;
					end
				end
			end
		end
	end

	// per-beat operands and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cycles_q     <= in_data.elapsed_cycles;
			cnt_period_q <= rate_period;
			rdata_q      <= (in_data.command == CMD_READ) ? read_mux : UNMAPPED_RD;
		end
		if (cmd.emit) begin
			out_q.read_data <= rdata_q;
			out_q.timer_irq <= irq_q;
		end
	end

endmodule
`default_nettype wire

[rtl/divider_and_reloading_timer_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// divider_and_reloading_timer_unit
// Emulated divider and reloading timer driven by tick and register beats.
//
// Input channel (in_valid/in_ready, in_data): one beat is a tick of elapsed
// cycles, a register read or a register write. Output channel (out_valid/
// out_ready, out_data): exactly one result beat per input beat, in order.
// A tick runs a subtract pass and then n step passes, where n is the larger
// number of step passes the divider or the counter needs (its period steps
// plus one pass that finds the budget positive, unless it wraps); both step
// in parallel, one period per cycle, so n is at most 256 and about 2048 /
// period + 2 for a saturated deficit. The next beat is accepted as soon as
// the sequencer is back in idle, even while the previous result still waits
// in the output register; a stalled receiver holds the sequencer in its done
// state until the slot frees. Reset sets the timer registers: divider and
// counter zero, counter stopped, budgets at the divider period and the
// rate 0 period, no result held.
// ----------------------------------------------------------------------------
module divider_and_reloading_timer_unit
	import drt_pkg::*;
#(
	parameter int DIVIDER_PERIOD = 256,
	parameter int RATE0_PERIOD   = 1024,
	parameter int RATE1_PERIOD   = 16,
	parameter int RATE2_PERIOD   = 64,
	parameter int RATE3_PERIOD   = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire in_t  in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	ctrl_cmd_t    cmd;
	ctrl_status_t status;

	drt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_command (in_data.command),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.cmd        (cmd)
	);

	drt_datapath #(
		.DIVIDER_PERIOD (DIVIDER_PERIOD),
		.RATE0_PERIOD   (RATE0_PERIOD),
		.RATE1_PERIOD   (RATE1_PERIOD),
		.RATE2_PERIOD   (RATE2_PERIOD),
		.RATE3_PERIOD   (RATE3_PERIOD)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

[bench/divider_and_reloading_timer_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// divider_and_reloading_timer_unit_test
// Self-checking bench for the divider and reloading timer unit.
//
// A short scripted sequence reads the registers out of reset, drives the
// counter through wraps with a full modulo until its deficit hits the floor,
// and pokes the divider, control and unmapped offsets. A random mix of ticks,
// reads and writes follows. Every accepted beat runs through a cycle-budget
// model of both counters kept in the bench, and each result beat is compared
// field by field with the oldest pending reply. Both handshakes stall at
// random, with one calm stretch in the middle of the random part.
// ----------------------------------------------------------------------------
module divider_and_reloading_timer_unit_test;
	import drt_pkg::*;

	localparam int DIV_PERIOD = 256;
	localparam int RATE0      = 1024;
	localparam int RATE1      = 16;
	localparam int RATE2      = 64;
	localparam int RATE3      = 256;

	localparam logic [3:0][11:0] RATE_PERIODS = {12'(RATE3), 12'(RATE2), 12'(RATE1), 12'(RATE0)};
	localparam int CREDIT_FLOOR = -(2 ** (BUDGET_W - 1));

	localparam logic [2:0] OFS_SPARE_LO = 3'd4;
	localparam logic [2:0] OFS_SPARE_HI = 3'd7;

	localparam int IDLE_PCT     = 14;
	localparam int RANDOM_BEATS = 500;
	localparam int CALM_FIRST   = 200;
	localparam int CALM_LAST    = 320;
	localparam int STUCK_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 200;
	localparam int REPORT_CAP   = 50;

	typedef struct packed {
		logic [7:0]                  value;
		logic signed [BUDGET_W-1:0]  credit;
		logic                        wrapped;
	} period_run_t;

	typedef struct packed {
		in_t  beat;
		logic fixed;
		out_t result;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	// expectation typed into the script travels with the beat
	logic beat_fixed = 1'b0;
	out_t beat_expect = '0;

	bit calm = 1'b0;
	int mismatches = 0;
	int results_seen = 0;
	int stuck_cycles = 0;
	out_t reply_queue[$];
	script_row_t script[$];

	// timer state as seen by the bench
	logic [7:0]                 div_count = '0;
	logic signed [BUDGET_W-1:0] div_credit = BUDGET_W'(DIV_PERIOD);
	logic [7:0]                 cnt_value = '0;
	logic signed [BUDGET_W-1:0] cnt_credit = BUDGET_W'(RATE0);
	logic                       cnt_run = 1'b0;
	logic [7:0]                 cnt_modulo = '0;
	logic [7:0]                 ctl_byte = '0;

	divider_and_reloading_timer_unit #(
		.DIVIDER_PERIOD(DIV_PERIOD),
		.RATE0_PERIOD(RATE0),
		.RATE1_PERIOD(RATE1),
		.RATE2_PERIOD(RATE2),
		.RATE3_PERIOD(RATE3)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < REPORT_CAP) begin
			$display("mismatch at result %0d: %s", results_seen, what);
		end
		mismatches++;
	endtask

	function automatic period_run_t run_periods(input logic [7:0] value,
			input logic signed [BUDGET_W-1:0] credit, input int period, input int cycles);
		period_run_t run;
		int left;
		left = credit;
		left = left - cycles;
		if (left < CREDIT_FLOOR) left = CREDIT_FLOOR;
		run.wrapped = 1'b0;
		while (left <= 0 && !run.wrapped) begin
			left = left + period;
			value = value + 8'd1;
			run.wrapped = (value == 8'd0);
		end
		run.value = value;
		run.credit = left[BUDGET_W-1:0];
		return run;
	endfunction

	function automatic out_t timer_step(input in_t beat);
		out_t res;
		period_run_t run;
		res = '0;
		case (beat.command)
			CMD_TICK: begin
				run = run_periods(div_count, div_credit, DIV_PERIOD, beat.elapsed_cycles);
				div_count = run.value;
				div_credit = run.credit;
				if (cnt_run) begin
					run = run_periods(cnt_value, cnt_credit,
						RATE_PERIODS[2'(ctl_byte & RATE_MASK)], beat.elapsed_cycles);
					cnt_credit = run.credit;
					if (run.wrapped) begin
						cnt_value = cnt_modulo;
						res.timer_irq = 1'b1;
					end else begin
						cnt_value = run.value;
					end
				end
			end
			CMD_READ: begin
				case (beat.reg_offset)
					OFS_DIVIDER: res.read_data = div_count;
					OFS_COUNTER: res.read_data = cnt_value;
					OFS_MODULO:  res.read_data = cnt_modulo;
					OFS_CONTROL: res.read_data = ctl_byte;
					default:     res.read_data = UNMAPPED_RD;
				endcase
			end
			CMD_WRITE: begin
				case (beat.reg_offset)
					OFS_DIVIDER: div_count = '0;
					OFS_COUNTER: cnt_value = beat.write_data;
					OFS_MODULO:  cnt_modulo = beat.write_data;
					OFS_CONTROL: begin
						ctl_byte = beat.write_data;
						cnt_run = beat.write_data[RUN_BIT];
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic script_row_t row_of(input command_t cmd, input logic [7:0] cycles,
			input logic [2:0] ofs, input logic [7:0] data, input logic fixed,
			input logic [7:0] rd, input logic irq);
		script_row_t row;
		row.beat.command = cmd;
		row.beat.elapsed_cycles = cycles;
		row.beat.reg_offset = ofs;
		row.beat.write_data = data;
		row.fixed = fixed;
		row.result.read_data = rd;
		row.result.timer_irq = irq;
		return row;
	endfunction

	function automatic in_t random_beat();
		in_t beat;
		int roll;
		beat = in_t'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 68) beat.command = CMD_TICK;
		else if (roll < 80) beat.command = CMD_READ;
		else if (roll < 97) beat.command = CMD_WRITE;
		else beat.command = CMD_NONE;
		roll = $urandom_range(0, 99);
		if (roll < 15) beat.elapsed_cycles = 8'hFF;
		else if (roll < 25) beat.elapsed_cycles = 8'h00;
		if ($urandom_range(0, 99) < 85) beat.reg_offset = 3'($urandom_range(OFS_DIVIDER, OFS_CONTROL));
		else beat.reg_offset = 3'($urandom_range(OFS_SPARE_LO, OFS_SPARE_HI));
		case (beat.reg_offset)
			OFS_MODULO: begin
				if ($urandom_range(0, 9) < 4) beat.write_data = 8'hFF;
			end
			OFS_CONTROL: begin
				if ($urandom_range(0, 9) < 8) beat.write_data[RUN_BIT] = 1'b1;
			end
			default: ;
		endcase
		return beat;
	endfunction

	task automatic send_beat(input in_t beat, input logic fixed, input out_t result);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		beat_fixed <= fixed;
		beat_expect <= result;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	always @(posedge clk) begin : monitor
		out_t want;
		out_t calc;
		logic moved;
		moved = 1'b0;
		if (out_valid && out_ready) begin
			moved = 1'b1;
			if (reply_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected beat %h", out_data));
			end else begin
				want = reply_queue.pop_front();
				if (out_data.read_data !== want.read_data)
					report_mismatch($sformatf("read_data %h, want %h",
						out_data.read_data, want.read_data));
				if (out_data.timer_irq !== want.timer_irq)
					report_mismatch($sformatf("timer_irq %b, want %b",
						out_data.timer_irq, want.timer_irq));
			end
			results_seen++;
		end
		if (in_valid && in_ready) begin
			moved = 1'b1;
			calc = timer_step(in_data);
			reply_queue.push_back(beat_fixed ? beat_expect : calc);
		end
		stuck_cycles = moved ? 0 : stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
		out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	initial begin : stimulus
		int n;
		// out of reset, unmapped offset, unknown command
		script.push_back(row_of(CMD_READ, 8'h00, OFS_DIVIDER, 8'h00, 1'b1, 8'h00, 1'b0));
		script.push_back(row_of(CMD_READ, 8'hFF, OFS_COUNTER, 8'hFF, 1'b1, 8'h00, 1'b0));
		script.push_back(row_of(CMD_READ, 8'h00, OFS_MODULO, 8'h00, 1'b1, 8'h00, 1'b0));
		script.push_back(row_of(CMD_READ, 8'h00, OFS_CONTROL, 8'h00, 1'b1, 8'h00, 1'b0));
		script.push_back(row_of(CMD_READ, 8'h00, OFS_SPARE_HI, 8'h00, 1'b1, UNMAPPED_RD, 1'b0));
		script.push_back(row_of(CMD_NONE, 8'hFF, OFS_SPARE_HI, 8'hFF, 1'b1, 8'h00, 1'b0));
		// stopped counter
		script.push_back(row_of(CMD_TICK, 8'h00, OFS_DIVIDER, 8'h00, 1'b0, 8'h00, 1'b0));
		script.push_back(row_of(CMD_WRITE, 8'h00, OFS_MODULO, 8'hFF, 1'b1, 8'h00, 1'b0));
		script.push_back(row_of(CMD_WRITE, 8'h00, OFS_COUNTER, 8'hFF, 1'b1, 8'h00, 1'b0));
		script.push_back(row_of(CMD_WRITE, 8'h00, OFS_CONTROL, 8'h05, 1'b1, 8'h00, 1'b0));
		// ticks that drain the budget, then wrap on each tick until the deficit saturates
		for (n = 0; n < 13; n++)
			script.push_back(row_of(CMD_TICK, 8'hFF, OFS_DIVIDER, 8'h00, 1'b0, 8'h00, 1'b0));
		script.push_back(row_of(CMD_WRITE, 8'h00, OFS_DIVIDER, 8'hAA, 1'b1, 8'h00, 1'b0));
		script.push_back(row_of(CMD_READ, 8'h00, OFS_DIVIDER, 8'h00, 1'b1, 8'h00, 1'b0));
		script.push_back(row_of(CMD_WRITE, 8'h00, OFS_CONTROL, 8'hFF, 1'b1, 8'h00, 1'b0));
		script.push_back(row_of(CMD_READ, 8'h00, OFS_CONTROL, 8'h00, 1'b1, 8'hFF, 1'b0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_beat(script[i].beat, script[i].fixed, script[i].result);
		for (n = 0; n < RANDOM_BEATS; n++) begin
			calm = (n >= CALM_FIRST && n < CALM_LAST);
			send_beat(random_beat(), 1'b0, '0);
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		while (reply_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
